>>> sv/dava_pkg.sv
`timescale 1ns / 1ps

package dava_pkg;

    localparam int VelW    = 32;
    localparam int CfgW    = 31;
    localparam int TargetW = 48;
    localparam int IdxW    = 2;

    // register indexes on the configuration port
    localparam logic [IdxW-1:0] REG_LIN_VEL_LIMIT  = 2'd0;
    localparam logic [IdxW-1:0] REG_LIN_ACCEL_STEP = 2'd1;
    localparam logic [IdxW-1:0] REG_ROT_VEL_LIMIT  = 2'd2;
    localparam logic [IdxW-1:0] REG_ROT_ACCEL_STEP = 2'd3;

    // reset values, unsigned Q7.24
    localparam logic [CfgW-1:0] LIN_VEL_LIMIT_RST  = 31'd134217728;
    localparam logic [CfgW-1:0] LIN_ACCEL_STEP_RST = 31'd335544;
    localparam logic [CfgW-1:0] ROT_VEL_LIMIT_RST  = 31'd335544;
    localparam logic [CfgW-1:0] ROT_ACCEL_STEP_RST = 31'd6711;

    typedef struct packed {
        logic signed [VelW-1:0] lin_setpoint;
        logic signed [VelW-1:0] rot_setpoint;
    } in_t;

    typedef struct packed {
        logic signed [VelW-1:0]    lin_velocity;
        logic signed [VelW-1:0]    rot_velocity;
        logic signed [TargetW-1:0] lin_target;
        logic signed [TargetW-1:0] rot_target;
    } out_t;

    typedef struct packed {
        logic [CfgW-1:0] limit;
        logic [CfgW-1:0] step;
    } axis_cfg_t;

endpackage

>>> sv/dava_axis.sv
`timescale 1ns / 1ps

module dava_axis
    import dava_pkg::*;
(
    input  axis_cfg_t              cfg,
    input  logic signed [VelW-1:0] vel,
    input  logic signed [VelW-1:0] setpoint,
    output logic signed [VelW-1:0] vel_new
);

    // 34 bits holds any difference of two 32-bit values plus a step
    logic signed [VelW+1:0] lim_s;
    logic signed [VelW+1:0] nlim_s;
    logic signed [VelW+1:0] stp_s;
    logic signed [VelW+1:0] vel_s;
    logic signed [VelW+1:0] sp_raw;
    logic signed [VelW+1:0] sp_c;
    logic signed [VelW+1:0] ramp;
    logic signed [VelW+1:0] clamped;

    always_comb
    begin
        lim_s  = $signed({3'b000, cfg.limit});
        nlim_s = -lim_s;
        stp_s  = $signed({3'b000, cfg.step});
        vel_s  = {{2{vel[VelW-1]}}, vel};
        sp_raw = {{2{setpoint[VelW-1]}}, setpoint};

        priority if (sp_raw > lim_s)
            sp_c = lim_s;
        else if (sp_raw < nlim_s)
            sp_c = nlim_s;
        else
            sp_c = sp_raw;

        // slew toward the clamped setpoint, snap when within one step
        priority if (vel_s > sp_c)
            ramp = ((vel_s - sp_c) < stp_s) ? sp_c : vel_s - stp_s;
        else if (vel_s < sp_c)
            ramp = ((sp_c - vel_s) < stp_s) ? sp_c : vel_s + stp_s;
        else
            ramp = vel_s;

        priority if (ramp > lim_s)
            clamped = lim_s;
        else if (ramp < nlim_s)
            clamped = nlim_s;
        else
            clamped = ramp;

        vel_new = clamped[VelW-1:0];
    end

endmodule

>>> sv/dual_axis_velocity_ramp_top.sv
`timescale 1ns / 1ps

// Two-axis velocity slew-rate limiter, one request per control tick.
// Input channel (in_valid/in_ready/in_data): linear and rotational velocity
// setpoints, signed Q8.24. Output channel (out_valid/out_ready/out_data):
// both ramped velocities and both Q24.24 position targets, which wrap.
// Config port: cfg_we with cfg_index/cfg_data writes one limit or step
// register; write only while no request is in flight.
// The result is registered into the output register, or the skid entry when
// that is held. Throughput: one request per clock while in_ready is high.
// The whole update (clamp, slew, clamp, target add) is combinational on the
// kept velocity and target registers; that chain sets the clock period.
// Stall: a result register plus a one-entry skid register sit at the output,
// so a request is still accepted while one result waits; in_ready drops
// only when both hold results.
// Reset: velocities and targets clear to zero, limits and steps return to
// their defaults, and both output entries are emptied.
module dual_axis_velocity_ramp_top
    import dava_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  in_t             in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output out_t            out_data,
    input  logic            cfg_we,
    input  logic [IdxW-1:0] cfg_index,
    input  logic [CfgW-1:0] cfg_data
);

    axis_cfg_t lin_cfg_reg;
    axis_cfg_t rot_cfg_reg;

    logic signed [VelW-1:0]    lin_vel_reg;
    logic signed [VelW-1:0]    rot_vel_reg;
    logic signed [TargetW-1:0] lin_target_reg;
    logic signed [TargetW-1:0] rot_target_reg;

    logic signed [VelW-1:0]    lin_vel_next;
    logic signed [VelW-1:0]    rot_vel_next;
    logic signed [TargetW-1:0] lin_target_next;
    logic signed [TargetW-1:0] rot_target_next;

    out_t result;
    out_t out_data_reg;
    out_t skid_data_reg;
    logic out_valid_reg;
    logic skid_valid_reg;

    logic in_fire;
    logic out_fire;
    logic out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_cfg_reg.limit <= LIN_VEL_LIMIT_RST;
            lin_cfg_reg.step  <= LIN_ACCEL_STEP_RST;
            rot_cfg_reg.limit <= ROT_VEL_LIMIT_RST;
            rot_cfg_reg.step  <= ROT_ACCEL_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LIN_VEL_LIMIT:  lin_cfg_reg.limit <= cfg_data;
                REG_LIN_ACCEL_STEP: lin_cfg_reg.step  <= cfg_data;
                REG_ROT_VEL_LIMIT:  rot_cfg_reg.limit <= cfg_data;
                REG_ROT_ACCEL_STEP: rot_cfg_reg.step  <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-axis ramp
    dava_axis u_lin_axis (
        .cfg      (lin_cfg_reg),
        .vel      (lin_vel_reg),
        .setpoint (in_data.lin_setpoint),
        .vel_new  (lin_vel_next)
    );

    dava_axis u_rot_axis (
        .cfg      (rot_cfg_reg),
        .vel      (rot_vel_reg),
        .setpoint (in_data.rot_setpoint),
        .vel_new  (rot_vel_next)
    );

    // targets wrap mod 2^48
    assign lin_target_next = lin_target_reg
                           + {{(TargetW-VelW){lin_vel_next[VelW-1]}}, lin_vel_next};
    assign rot_target_next = rot_target_reg
                           + {{(TargetW-VelW){rot_vel_next[VelW-1]}}, rot_vel_next};

    always_comb
    begin
        result.lin_velocity = lin_vel_next;
        result.rot_velocity = rot_vel_next;
        result.lin_target   = lin_target_next;
        result.rot_target   = rot_target_next;
    end

    // handshakes
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_fire  = out_valid_reg && out_ready;
    // output register is free for a new load this cycle
    assign out_free  = !out_valid_reg || out_fire;

    // kept state advances on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_vel_reg    <= '0;
            rot_vel_reg    <= '0;
            lin_target_reg <= '0;
            rot_target_reg <= '0;
        end
        else if (in_fire)
        begin
            lin_vel_reg    <= lin_vel_next;
            rot_vel_reg    <= rot_vel_next;
            lin_target_reg <= lin_target_next;
            rot_target_reg <= rot_target_next;
        end
    end

    // output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                // no request is taken while the skid entry is full
                if (out_fire)
                    skid_valid_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                if (out_free)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (in_fire)
        begin
            if (out_free)
                out_data_reg <= result;
            else
                skid_data_reg <= result;
        end
    end

endmodule

>>> tb/tb_dual_axis_velocity_ramp_top.sv
`timescale 1ns / 1ps

module tb_dual_axis_velocity_ramp_top;
    import dava_pkg::*;

    // Run length guard. The slowest correct run is about 420 requests, a
    // third of them under heavy receiver stalls and a third under heavy
    // sender gaps, plus a drain and four register writes per burst; this
    // limit is set far above what such a run needs.
    localparam int MAX_CYCLES = 40000;

    localparam logic [CfgW-1:0]        CFG_MAX = '1;
    localparam logic signed [VelW-1:0] VEL_MAX = 32'sh7fffffff;
    localparam logic signed [VelW-1:0] VEL_MIN = 32'sh80000000;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    in_t             in_data   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    out_t            out_data;
    logic            cfg_we    = 1'b0;
    logic [IdxW-1:0] cfg_index = REG_LIN_VEL_LIMIT;
    logic [CfgW-1:0] cfg_data  = '0;

    dual_axis_velocity_ramp_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Setpoint requests waiting to be driven, and ramp results owed by the
    // block in acceptance order.
    in_t  setpoint_q[$];
    out_t ramp_due[$];

    // Our copy of the block's registers. Written only while the block is
    // idle, so a request always sees the same settings on both sides.
    logic [CfgW-1:0] lin_limit_cfg = LIN_VEL_LIMIT_RST;
    logic [CfgW-1:0] lin_step_cfg  = LIN_ACCEL_STEP_RST;
    logic [CfgW-1:0] rot_limit_cfg = ROT_VEL_LIMIT_RST;
    logic [CfgW-1:0] rot_step_cfg  = ROT_ACCEL_STEP_RST;

    // Predicted kept velocities and position targets.
    logic signed [VelW-1:0] lin_vel_q = '0;
    logic signed [VelW-1:0] rot_vel_q = '0;
    logic [TargetW-1:0]     lin_pos_q = '0;
    logic [TargetW-1:0]     rot_pos_q = '0;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   mismatches    = 0;
    int   cycle_count   = 0;
    logic req_taken     = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Symmetric clamp to +/- lim; done in 64 bits so -lim never overflows.
    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // One axis for one tick: clamp the setpoint, slew toward it by at most
    // one step (taking it exactly when closer than a step), clamp again.
    // The second clamp is what pulls a velocity down when the limit drops.
    function automatic logic signed [VelW-1:0] slew_axis(
        input logic signed [VelW-1:0] vel,
        input logic signed [VelW-1:0] setpoint,
        input logic [CfgW-1:0]        limit,
        input logic [CfgW-1:0]        step
    );
        longint lim;
        longint stp;
        longint sp;
        longint v;
        lim = longint'(limit);
        stp = longint'(step);
        v   = longint'(vel);
        sp  = clamp_sym(longint'(setpoint), lim);
        if (v > sp)
        begin
            if (v - sp < stp)
                v = sp;
            else
                v = v - stp;
        end
        else if (v < sp)
        begin
            if (sp - v < stp)
                v = sp;
            else
                v = v + stp;
        end
        v = clamp_sym(v, lim);
        return v[VelW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Setpoint shaping: a quarter fully random, a quarter a small walk from
    // the last one (so the velocity settles and snaps), a quarter inside the
    // limit, and a quarter right at +/- limit.
    function automatic logic signed [VelW-1:0] pick_setpoint(
        input logic [CfgW-1:0]        limit,
        input logic signed [VelW-1:0] prev
    );
        logic signed [VelW-1:0] raw;
        longint lim;
        longint r;
        lim = longint'(limit);
        raw = $urandom;
        case ($urandom_range(3))
            0: r = longint'(raw);
            1: r = longint'(prev) + longint'($urandom_range(4000)) - 2000;
            2:
            begin
                r = longint'($urandom) % (lim + 1);
                if ($urandom_range(1) == 1)
                    r = -r;
            end
            default:
            begin
                r = ($urandom_range(1) == 1) ? lim : -lim;
                r = r + longint'($urandom_range(2)) - 1;
            end
        endcase
        return r[VelW-1:0];
    endfunction

    // Register values: zero and full scale now and then, otherwise either
    // any 31-bit value or a realistic size (limits a few units, steps small).
    function automatic logic [CfgW-1:0] pick_cfg(input bit is_step);
        logic [CfgW-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = CFG_MAX;
            2, 3: v = CfgW'($urandom);
            default: v = is_step ? CfgW'($urandom_range(1, 1 << 20))
                                 : CfgW'($urandom_range(1, 1 << 26));
        endcase
        return v;
    endfunction

    task automatic push_setpoint(input logic signed [VelW-1:0] lin,
                                 input logic signed [VelW-1:0] rot);
        in_t req;
        req.lin_setpoint = lin;
        req.rot_setpoint = rot;
        setpoint_q.push_back(req);
    endtask

    // Hold off until nothing is queued, nothing is waiting on the bus and
    // every result is in, then give the registered output time to settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (setpoint_q.size() != 0 || (in_valid && !req_taken) || ramp_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_LIN_VEL_LIMIT:  lin_limit_cfg = value;
            REG_LIN_ACCEL_STEP: lin_step_cfg  = value;
            REG_ROT_VEL_LIMIT:  rot_limit_cfg = value;
            REG_ROT_ACCEL_STEP: rot_step_cfg  = value;
            default: ;
        endcase
    endtask

    // Back-to-back writes keep cfg_we high; it drops once after the last.
    task automatic set_axes(input logic [CfgW-1:0] lin_limit, input logic [CfgW-1:0] lin_step,
                            input logic [CfgW-1:0] rot_limit, input logic [CfgW-1:0] rot_step);
        write_reg(REG_LIN_VEL_LIMIT, lin_limit);
        write_reg(REG_LIN_ACCEL_STEP, lin_step);
        write_reg(REG_ROT_VEL_LIMIT, rot_limit);
        write_reg(REG_ROT_ACCEL_STEP, rot_step);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random requests in bursts; each burst starts from a drained block with
    // fresh register settings, so the sender also pauses for a full drain.
    task automatic run_random(input int send_pct, input int recv_pct, input int total);
        int left;
        int burst;
        logic signed [VelW-1:0] lin_prev;
        logic signed [VelW-1:0] rot_prev;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        left     = total;
        lin_prev = '0;
        rot_prev = '0;
        while (left > 0)
        begin
            wait_drained();
            set_axes(pick_cfg(1'b0), pick_cfg(1'b1), pick_cfg(1'b0), pick_cfg(1'b1));
            burst = $urandom_range(15, 40);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                lin_prev = pick_setpoint(lin_limit_cfg, lin_prev);
                rot_prev = pick_setpoint(rot_limit_cfg, rot_prev);
                push_setpoint(lin_prev, rot_prev);
            end
            left = left - burst;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes at the falling edge, holds a request until the
    // rising edge that takes it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken))
        begin
            if (setpoint_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= setpoint_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // On each accepted request advance the predicted state and queue the
    // result it must produce. Targets wrap modulo 2^48.
    always @(posedge clk)
    begin
        out_t due;
        req_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            lin_vel_q = slew_axis(lin_vel_q, in_data.lin_setpoint, lin_limit_cfg, lin_step_cfg);
            rot_vel_q = slew_axis(rot_vel_q, in_data.rot_setpoint, rot_limit_cfg, rot_step_cfg);
            lin_pos_q = lin_pos_q + {{(TargetW - VelW){lin_vel_q[VelW-1]}}, lin_vel_q};
            rot_pos_q = rot_pos_q + {{(TargetW - VelW){rot_vel_q[VelW-1]}}, rot_vel_q};
            due.lin_velocity = lin_vel_q;
            due.rot_velocity = rot_vel_q;
            due.lin_target   = lin_pos_q;
            due.rot_target   = rot_pos_q;
            ramp_due.push_back(due);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (ramp_due.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = ramp_due.pop_front();
                check_field("lin_velocity", 64'(want.lin_velocity),
                            64'(out_data.lin_velocity));
                check_field("rot_velocity", 64'(want.rot_velocity),
                            64'(out_data.rot_velocity));
                check_field("lin_target", 64'(want.lin_target), 64'(out_data.lin_target));
                check_field("rot_target", 64'(want.rot_target), 64'(out_data.rot_target));
            end
        end
    end

    // Hang guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, light sender gaps and heavy receiver stalls.
        send_idle_pct = 7;
        recv_idle_pct = 85;

        // Reset settings: rest, full-scale setpoints both ways, sign edges.
        push_setpoint('0, '0);
        push_setpoint(VEL_MAX, VEL_MAX);
        push_setpoint(VEL_MAX, VEL_MAX);
        push_setpoint(VEL_MIN, VEL_MIN);
        push_setpoint(-1, 1);
        push_setpoint(1, -1);

        // Zero limits: setpoint and velocity forced to zero.
        wait_drained();
        set_axes('0, LIN_ACCEL_STEP_RST, '0, ROT_ACCEL_STEP_RST);
        push_setpoint(VEL_MAX, VEL_MIN);
        push_setpoint(12345, -12345);

        // Zero steps: velocity stays put.
        wait_drained();
        set_axes(CFG_MAX, '0, CFG_MAX, '0);
        push_setpoint(VEL_MAX, VEL_MIN);
        push_setpoint('0, '0);

        // Full-scale limits and steps: jump to the rail, back to zero, then to the rail again.
        wait_drained();
        set_axes(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        push_setpoint(VEL_MAX, VEL_MIN);
        push_setpoint(VEL_MIN, VEL_MAX);
        push_setpoint(VEL_MAX, VEL_MIN);

        // Limit dropped under the kept velocity with no step: the output
        // clamp alone must pull it in on the next tick.
        wait_drained();
        set_axes(31'd16777216, '0, 31'd1048576, '0);
        push_setpoint(VEL_MAX, VEL_MIN);

        // Random part in three idling modes.
        run_random(7, 85, 130);
        run_random(85, 7, 130);
        run_random(0, 0, 140);

        wait_drained();
        repeat (5) @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
